[hw/rtl/wsc_pkg.sv]
// wsc_pkg: shared types and constants of the wiper sweep controller
// word layouts, mode and delay codes, register indexes and reset values
// depends on nothing
package wsc_pkg;

    typedef struct packed {
        logic [15:0] mode_reading;
        logic [15:0] delay_reading;
        logic        engine_running;
        logic [9:0]  elapsed_ms;
    } t_in_word;

    typedef struct packed {
        logic [15:0] duty;
        logic [14:0] sweep_angle;
        logic [1:0]  cycle_phase;
        logic [1:0]  running_mode;
        logic [1:0]  wanted_mode;
        logic [1:0]  delay_choice;
    } t_out_word;

    // load strobes of the two duty scaling stages
    typedef struct packed {
        logic ld_est;
        logic ld_out;
    } t_duty_ctl;

    // mode codes
    localparam logic [1:0] MD_OFF  = 2'd0;
    localparam logic [1:0] MD_HIGH = 2'd1;
    localparam logic [1:0] MD_LOW  = 2'd2;
    localparam logic [1:0] MD_INT  = 2'd3;

    // delay choice codes
    localparam logic [1:0] DLY_SHORT  = 2'd0;
    localparam logic [1:0] DLY_MEDIUM = 2'd1;
    localparam logic [1:0] DLY_LONG   = 2'd2;

    // delay knob thresholds: first readings at or above 0.33 and 0.66 of full scale
    localparam logic [15:0] DLY_T1 = 16'd21627;
    localparam logic [15:0] DLY_T2 = 16'd43254;

    // register indexes
    localparam logic [2:0] CFG_OFF_THR  = 3'd0;
    localparam logic [2:0] CFG_HIGH_THR = 3'd1;
    localparam logic [2:0] CFG_LOW_THR  = 3'd2;
    localparam logic [2:0] CFG_FAST_SPD = 3'd3;
    localparam logic [2:0] CFG_SLOW_SPD = 3'd4;
    localparam logic [2:0] CFG_SHORT_DLY = 3'd5;
    localparam logic [2:0] CFG_MED_DLY  = 3'd6;
    localparam logic [2:0] CFG_LONG_DLY = 3'd7;

    // register reset values
    localparam logic [15:0] RST_OFF_THR   = 16'd16384;
    localparam logic [15:0] RST_HIGH_THR  = 16'd32768;
    localparam logic [15:0] RST_LOW_THR   = 16'd49152;
    localparam logic [11:0] RST_FAST_SPD  = 12'd64;
    localparam logic [11:0] RST_SLOW_SPD  = 12'd32;
    localparam logic [15:0] RST_SHORT_DLY = 16'd3000;
    localparam logic [15:0] RST_MED_DLY   = 16'd6000;
    localparam logic [15:0] RST_LONG_DLY  = 16'd8000;

    // pause timer ceiling
    localparam logic [16:0] PAUSE_MAX = 17'h1FFFF;

    // fraction bits of the duty reciprocal
    localparam int unsigned DUTY_K = 16;

endpackage

[hw/rtl/wsc_duty.sv]
// wsc_duty: two-stage scaling of the wiper angle to servo duty
// duty = floor(angle * 65535 / max angle), reciprocal estimate then remainder fix
// depends on wsc_pkg
module wsc_duty
    import wsc_pkg::*;
#(
    parameter int unsigned MAX_ANGLE_Q8 = 23040
) (
    input  logic                                i_clk,
    input  t_duty_ctl                           i_ctl,
    input  logic [$clog2(MAX_ANGLE_Q8+1)-1:0]   i_angle,
    output logic [15:0]                         o_duty
);

    localparam int unsigned AW = $clog2(MAX_ANGLE_Q8 + 1);
    localparam longint unsigned RECIP = (64'd65535 << DUTY_K) / MAX_ANGLE_Q8;
    localparam int unsigned RW = $clog2(RECIP + 1);
    localparam int unsigned PW = AW + RW;
    localparam int unsigned YW = AW + 16;
    localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
    localparam logic [YW-1:0] MAX_Y = YW'(MAX_ANGLE_Q8);

    logic [PW-1:0] w_prod;
    logic [15:0]   w_est;
    logic [YW-1:0] w_y;
    logic [YW-1:0] w_qm;
    logic [YW-1:0] w_rem;

    logic [15:0]   r_est;
    logic [YW-1:0] r_y;
    logic [15:0]   r_duty;

    // estimate is the true quotient or one below it
    assign w_prod = PW'(i_angle) * PW'(RECIP_C);
    assign w_est  = 16'(w_prod >> DUTY_K);
    assign w_y    = {i_angle, 16'b0} - YW'(i_angle);

    assign w_qm  = YW'(r_est) * MAX_Y;
    assign w_rem = r_y - w_qm;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_est) begin
            r_est <= w_est;
            r_y   <= w_y;
        end
        if (i_ctl.ld_out) begin
            r_duty <= (w_rem >= MAX_Y) ? r_est + 16'd1 : r_est;
        end
    end

    assign o_duty = r_duty;

endmodule

[hw/rtl/wiper_sweep_controller.sv]
// wiper_sweep_controller: a word accepted into the input register passes the state
//   update, duty estimate and duty fix registers before it is shown on o_data
// throughput one word per cycle unless the output stalls: four register stages
//   (input, state update, duty estimate, duty fix) advance under a ready chain
// reset (i_rst_n low, synchronous): idle, mode off, angle and pause timer zero,
//   registers back to their defaults, pipeline empty
// depends on wsc_pkg and wsc_duty
module wiper_sweep_controller
    import wsc_pkg::*;
#(
    parameter int unsigned MAX_ANGLE_Q8 = 23040
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_word    i_data,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_word   o_data,
    // register write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int unsigned AW    = $clog2(MAX_ANGLE_Q8 + 1);
    localparam int unsigned STEPW = 22;
    localparam int unsigned SUMW  = ((AW > STEPW) ? AW : STEPW) + 1;
    localparam logic [AW-1:0] MAX_A = AW'(MAX_ANGLE_Q8);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_UP    = 2'd1,
        PH_DOWN  = 2'd2,
        PH_PAUSE = 2'd3
    } t_phase;

    // configuration registers
    logic [15:0] r_off_thr, r_high_thr, r_low_thr;
    logic [11:0] r_fast_spd, r_slow_spd;
    logic [15:0] r_short_dly, r_med_dly, r_long_dly;

    // sweep state
    t_phase      r_phase, n_phase;
    logic [1:0]  r_mode, n_mode;
    logic [AW-1:0] r_angle, n_angle;
    logic [16:0] r_pause_el, n_pause_el;
    logic [15:0] r_pause_len, n_pause_len;

    // pipeline
    logic        r_v1, r_v2, r_v3, r_v4;
    t_in_word    r_in;
    logic [AW-1:0] r2_angle;
    t_out_word   r2_word, r3_word, r4_word;
    t_out_word   n_word;

    logic        w_rdy2, w_rdy3, w_rdy4;
    logic        w_adv12, w_adv23, w_adv34;
    t_duty_ctl   w_duty_ctl;
    logic [15:0] w_duty;

    // decode and step helpers
    logic [1:0]       w_wanted, w_dchoice;
    logic [15:0]      w_dlen;
    logic [11:0]      w_speed;
    logic [STEPW-1:0] w_step;
    logic [SUMW-1:0]  w_sum;
    logic [17:0]      w_pe_sum;

    //------------------------------------------------------------------
    // handshake chain: a stage takes a word when it is empty or drains
    //------------------------------------------------------------------
    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign o_ready = !r_v1 || w_rdy2;

    assign w_adv12 = r_v1 && w_rdy2;
    assign w_adv23 = r_v2 && w_rdy3;
    assign w_adv34 = r_v3 && w_rdy4;

    assign o_valid     = r_v4;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (o_ready) r_v1 <= i_valid;
            if (w_rdy2)  r_v2 <= r_v1;
            if (w_rdy3)  r_v3 <= r_v2;
            if (w_rdy4)  r_v4 <= r_v3;
        end
    end

    // input register, no reset on payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_data;
        end
    end

    //------------------------------------------------------------------
    // register writes
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_thr   <= RST_OFF_THR;
            r_high_thr  <= RST_HIGH_THR;
            r_low_thr   <= RST_LOW_THR;
            r_fast_spd  <= RST_FAST_SPD;
            r_slow_spd  <= RST_SLOW_SPD;
            r_short_dly <= RST_SHORT_DLY;
            r_med_dly   <= RST_MED_DLY;
            r_long_dly  <= RST_LONG_DLY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OFF_THR:   r_off_thr   <= i_cfg_data;
                CFG_HIGH_THR:  r_high_thr  <= i_cfg_data;
                CFG_LOW_THR:   r_low_thr   <= i_cfg_data;
                CFG_FAST_SPD:  r_fast_spd  <= i_cfg_data[11:0];
                CFG_SLOW_SPD:  r_slow_spd  <= i_cfg_data[11:0];
                CFG_SHORT_DLY: r_short_dly <= i_cfg_data;
                CFG_MED_DLY:   r_med_dly   <= i_cfg_data;
                CFG_LONG_DLY:  r_long_dly  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // knob decode: thresholds tested in order, no ordering check
    //------------------------------------------------------------------
    always_comb begin
        if (r_in.mode_reading < r_off_thr)       w_wanted = MD_OFF;
        else if (r_in.mode_reading < r_high_thr) w_wanted = MD_HIGH;
        else if (r_in.mode_reading < r_low_thr)  w_wanted = MD_LOW;
        else                                     w_wanted = MD_INT;

        if (r_in.delay_reading < DLY_T1) begin
            w_dchoice = DLY_SHORT;
            w_dlen    = r_short_dly;
        end else if (r_in.delay_reading < DLY_T2) begin
            w_dchoice = DLY_MEDIUM;
            w_dlen    = r_med_dly;
        end else begin
            w_dchoice = DLY_LONG;
            w_dlen    = r_long_dly;
        end
    end

    //------------------------------------------------------------------
    // sweep cycle next state
    //------------------------------------------------------------------
    always_comb begin
        n_phase     = r_phase;
        n_mode      = r_mode;
        n_angle     = r_angle;
        n_pause_el  = r_pause_el;
        n_pause_len = r_pause_len;

        // off keeps the running mode until the cycle is back in idle
        if (r_in.engine_running) begin
            if (w_wanted != MD_OFF)     n_mode = w_wanted;
            else if (r_phase == PH_IDLE) n_mode = MD_OFF;
        end

        case (n_mode)
            MD_HIGH: w_speed = r_fast_spd;
            MD_OFF:  w_speed = 12'd0;
            default: w_speed = r_slow_spd;
        endcase
        w_step   = STEPW'(w_speed) * STEPW'(r_in.elapsed_ms);
        w_sum    = SUMW'(r_angle) + SUMW'(w_step);
        w_pe_sum = 18'(r_pause_el) + 18'(r_in.elapsed_ms);

        if (!r_in.engine_running) begin
            // dead engine freezes a running cycle, idle parks the wiper
            if (r_phase == PH_IDLE) begin
                n_angle = '0;
                n_mode  = MD_OFF;
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (n_mode != MD_OFF) begin
                        n_phase = PH_UP;
                        n_angle = '0;
                    end
                end
                PH_UP: begin
                    if (w_sum >= SUMW'(MAX_A)) begin
                        n_angle = MAX_A;
                        n_phase = PH_DOWN;
                    end else begin
                        n_angle = AW'(w_sum);
                    end
                end
                PH_DOWN: begin
                    if (SUMW'(w_step) >= SUMW'(r_angle)) begin
                        n_angle = '0;
                        if (n_mode == MD_INT) begin
                            n_phase     = PH_PAUSE;
                            n_pause_el  = '0;
                            n_pause_len = w_dlen;
                        end else if (r_in.mode_reading < r_off_thr) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_UP;
                        end
                    end else begin
                        n_angle = r_angle - AW'(w_step);
                    end
                end
                default: begin
                    // saturating pause timer
                    n_pause_el = w_pe_sum[17] ? PAUSE_MAX : w_pe_sum[16:0];
                    if (n_pause_el >= {1'b0, r_pause_len}) begin
                        if (r_in.mode_reading < r_off_thr) n_phase = PH_IDLE;
                        else                                n_phase = PH_UP;
                    end
                end
            endcase
        end

        n_word              = '0;
        n_word.sweep_angle  = 15'(n_angle);
        n_word.cycle_phase  = n_phase;
        n_word.running_mode = n_mode;
        n_word.wanted_mode  = w_wanted;
        n_word.delay_choice = w_dchoice;
    end

    // state and stage two words move together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_mode      <= MD_OFF;
            r_angle     <= '0;
            r_pause_el  <= '0;
            r_pause_len <= '0;
        end else if (w_adv12) begin
            r_phase     <= n_phase;
            r_mode      <= n_mode;
            r_angle     <= n_angle;
            r_pause_el  <= n_pause_el;
            r_pause_len <= n_pause_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv12) begin
            r2_word  <= n_word;
            r2_angle <= n_angle;
        end
        if (w_adv23) r3_word <= r2_word;
        if (w_adv34) r4_word <= r3_word;
    end

    //------------------------------------------------------------------
    // duty scaling alongside stages three and four
    //------------------------------------------------------------------
    assign w_duty_ctl.ld_est = w_adv23;
    assign w_duty_ctl.ld_out = w_adv34;

    wsc_duty #(
        .MAX_ANGLE_Q8 (MAX_ANGLE_Q8)
    ) u_duty (
        .i_clk   (i_clk),
        .i_ctl   (w_duty_ctl),
        .i_angle (r2_angle),
        .o_duty  (w_duty)
    );

    always_comb begin
        o_data      = r4_word;
        o_data.duty = w_duty;
    end

    //------------------------------------------------------------------
    // checks
    //------------------------------------------------------------------
    // angle saturates at the top of the sweep
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_angle <= MAX_A)
        else $error("wiper angle above maximum");

    // a dead engine in idle parks the wiper
    a_park: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv12 && !r_in.engine_running && r_phase == PH_IDLE)
        |=> (r_angle == '0 && r_mode == MD_OFF))
        else $error("idle with engine off did not park");

    // a pause starts only in intermittent mode with a cleared timer
    a_pause_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_phase == PH_PAUSE) |-> (r_mode == MD_INT && r_pause_el == '0))
        else $error("pause entered outside intermittent mode");

endmodule
